// ----- hdl/texture_mip_tile_layout_unit_macros.svh -----
// Assertion macros shared by the texture mip tile layout modules.
// Every macro assumes a clock named clk_i and an active-low reset named rst_ni.
`ifndef TEXTURE_MIP_TILE_LAYOUT_UNIT_MACROS_SVH
`define TEXTURE_MIP_TILE_LAYOUT_UNIT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define TMTL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define TMTL_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hdl/tmtl_pkg.sv -----
// Shared types, constants and helper functions for the texture mip tile layout unit.
// No dependencies; every module of the block imports this package.
package tmtl_pkg;

  // Default and largest supported number of mip levels.
  localparam int unsigned MaxLevels = 8;

  // Entries in the queue between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  // Steps of the serial divider, one quotient bit per step.
  localparam int unsigned DivSteps = 12;

  // Texel depth codes.
  localparam logic [1:0] Depth4b  = 2'd0;
  localparam logic [1:0] Depth8b  = 2'd1;
  localparam logic [1:0] Depth16b = 2'd2;
  localparam logic [1:0] Depth32b = 2'd3;

  // Load texel size codes.
  localparam logic [1:0] SizeCode16 = 2'd2;
  localparam logic [1:0] SizeCode32 = 2'd3;

  // Scale over granularity: 2048 for every depth but 32 bit, which uses 1024.
  localparam logic [11:0] DxtScaleWide   = 12'd2048;
  localparam logic [11:0] DxtScaleNarrow = 12'd1024;

  // One classified texture, handed from the front part to the back part.
  typedef struct packed {
    logic [10:0] w0;
    logic [10:0] h0;
    logic [1:0]  depth;
    logic [3:0]  count;
    logic [11:0] corner;
    logic [18:0] last;
    logic [11:0] dxt;
  } tmtl_job_t;

  // Row length in 64-bit words for a row of w texels.
  function automatic logic [9:0] row_words(logic [1:0] depth, logic [10:0] w);
    logic [11:0] t;
    t = {1'b0, w};
    case (depth)
      Depth4b: t = (t + 12'd15) >> 4;
      Depth8b: t = (t + 12'd7) >> 3;
      default: t = (t + 12'd3) >> 2;
    endcase
    return t[9:0];
  endfunction

  // Next mip dimension: halved, but one and zero stay as they are.
  function automatic logic [10:0] halve(logic [10:0] v);
    return (v >= 11'd2) ? (v >> 1) : v;
  endfunction

  // Ceiling log2 clamped to eight, zero below two.
  function automatic logic [3:0] wrap_mask(logic [10:0] n);
    logic [3:0] r;
    r = 4'd8;
    for (int k = 7; k >= 1; k--) begin
      if (n <= (11'd1 << k)) r = 4'(k);
    end
    if (n < 11'd2) r = 4'd0;
    return r;
  endfunction

endpackage

// ----- hdl/texture_mip_tile_layout_unit.sv -----
// Texture mip tile layout unit. Each accepted transaction describes one texture
// (width, height, texel depth, mip level count, corner offset) and yields one tile
// setup per level, from one up to MAX_LEVELS, the last one flagged by last_level_o.
// The front part accepts a texture and then works on it, accumulating the load-block
// count one level per cycle. A texture without mipmaps (a level count of zero) also
// gets its dxt step from a 12-step serial divider running alongside. The front then
// offers the job to the queue and takes no new texture until the queue has taken it.
// A two-entry queue then feeds the back part. The back part loads a texture when idle
// and then emits one level result per cycle through an output register while the
// receiver is ready, so the front works on the next texture while results drain.
// Depends on tmtl_pkg, tmtl_fifo, tmtl_front and tmtl_back.
module texture_mip_tile_layout_unit import tmtl_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [10:0] tex_width_i,
  input  logic [10:0] tex_height_i,
  input  logic [1:0]  depth_code_i,
  input  logic [3:0]  mip_levels_i,
  input  logic [11:0] corner_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  tile_index_o,
  output logic [8:0]  line_words_o,
  output logic [18:0] tmem_addr_o,
  output logic [3:0]  mask_s_o,
  output logic [3:0]  mask_t_o,
  output logic [18:0] load_last_texel_o,
  output logic [11:0] load_dxt_o,
  output logic [1:0]  load_size_code_o,
  output logic [12:0] lower_right_s_o,
  output logic [12:0] lower_right_t_o,
  output logic        last_level_o
);

  logic      push_valid, push_ready;
  logic      pop_valid, pop_ready;
  tmtl_job_t push_data, pop_data;

  // Front part: accept and classify.
  tmtl_front #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tex_width_i    (tex_width_i),
    .tex_height_i   (tex_height_i),
    .depth_code_i   (depth_code_i),
    .mip_levels_i   (mip_levels_i),
    .corner_offset_i(corner_offset_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  // Queue between the two parts.
  tmtl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Back part: per-level results.
  tmtl_back #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tile_index_o     (tile_index_o),
    .line_words_o     (line_words_o),
    .tmem_addr_o      (tmem_addr_o),
    .mask_s_o         (mask_s_o),
    .mask_t_o         (mask_t_o),
    .load_last_texel_o(load_last_texel_o),
    .load_dxt_o       (load_dxt_o),
    .load_size_code_o (load_size_code_o),
    .lower_right_s_o  (lower_right_s_o),
    .lower_right_t_o  (lower_right_t_o),
    .last_level_o     (last_level_o)
  );

endmodule

// ----- hdl/tmtl_fifo.sv -----
// Small queue of classified textures between the front and back parts.
// Depends on tmtl_pkg for the job type and the queue depth.
module tmtl_fifo import tmtl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  tmtl_job_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output tmtl_job_t pop_data_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tmtl_job_t           mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     fill_q, fill_d;
  logic                do_push, do_pop;

  assign push_ready_o = (fill_q != CntW'(QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/tmtl_front.sv -----
// Front part: accepts a texture, accumulates the load-block count over its levels
// and runs the serial dxt divider, then queues the result. Depends on tmtl_pkg.
`include "texture_mip_tile_layout_unit_macros.svh"

module tmtl_front import tmtl_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [10:0] tex_width_i,
  input  logic [10:0] tex_height_i,
  input  logic [1:0]  depth_code_i,
  input  logic [3:0]  mip_levels_i,
  input  logic [11:0] corner_offset_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output tmtl_job_t   push_data_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CALC = 3'b010,
    F_PUSH = 3'b100
  } front_state_e;

  front_state_e state_q, state_d;
  tmtl_job_t    job_q, job_d;
  logic [10:0]  w_q, w_d, h_q, h_d;
  logic [3:0]   left_q, left_d;
  logic [18:0]  sum_q, sum_d;
  logic         div_busy_q, div_busy_d;
  logic [3:0]   div_cnt_q, div_cnt_d;
  logic [9:0]   rem_q, rem_d;
  logic [11:0]  num_q, num_d;
  logic [9:0]   divisor_q, divisor_d;

  logic [3:0]   count_in;
  logic [9:0]   rw_first;
  logic [9:0]   rw_cur;
  logic [20:0]  level_prod;
  logic [10:0]  rem_shift;
  logic         rem_ge;

  // Clamp the level count; no mipmapping means a single level.
  always_comb begin
    priority if (mip_levels_i == 4'd0) begin
      count_in = 4'd1;
    end else if (mip_levels_i > 4'(MAX_LEVELS)) begin
      count_in = 4'(MAX_LEVELS);
    end else begin
      count_in = mip_levels_i;
    end
  end

  assign rw_first   = row_words(depth_code_i, tex_width_i);
  assign rw_cur     = row_words(job_q.depth, w_q);
  assign level_prod = 21'(rw_cur) * 21'(h_q);
  assign rem_shift  = {rem_q, num_q[11]};
  assign rem_ge     = (rem_shift >= {1'b0, divisor_q});

  // Sequencing: the level sum and the divider run side by side.
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    w_d        = w_q;
    h_d        = h_q;
    left_d     = left_q;
    sum_d      = sum_q;
    div_busy_d = div_busy_q;
    div_cnt_d  = div_cnt_q;
    rem_d      = rem_q;
    num_d      = num_q;
    divisor_d  = divisor_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          job_d.w0     = tex_width_i;
          job_d.h0     = tex_height_i;
          job_d.depth  = depth_code_i;
          job_d.count  = count_in;
          job_d.corner = corner_offset_i;
          w_d          = tex_width_i;
          h_d          = tex_height_i;
          left_d       = count_in;
          sum_d        = '0;
          rem_d        = '0;
          div_cnt_d    = '0;
          divisor_d    = rw_first;
          if ((mip_levels_i == 4'd0) && (rw_first != 10'd0)) begin
            div_busy_d = 1'b1;
            num_d      = ((depth_code_i == Depth32b) ? DxtScaleNarrow : DxtScaleWide)
                         + 12'(rw_first) - 12'd1;
          end else begin
            div_busy_d = 1'b0;
            num_d      = '0;
          end
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        if (left_q != 4'd0) begin
          sum_d  = sum_q + 19'({level_prod, 2'b00});
          w_d    = halve(w_q);
          h_d    = halve(h_q);
          left_d = left_q - 4'd1;
        end
        // Restoring division, one quotient bit per cycle.
        if (div_busy_q) begin
          rem_d     = rem_ge ? 10'(rem_shift - {1'b0, divisor_q}) : rem_shift[9:0];
          num_d     = {num_q[10:0], rem_ge};
          div_cnt_d = div_cnt_q + 4'd1;
          if (div_cnt_q == 4'(DivSteps - 1)) begin
            div_busy_d = 1'b0;
          end
        end
        if ((left_q == 4'd0) && !div_busy_q) begin
          job_d.last = sum_q - 19'd1;
          job_d.dxt  = num_q;
          state_d    = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      div_busy_q <= 1'b0;
      left_q     <= '0;
    end else begin
      state_q    <= state_d;
      div_busy_q <= div_busy_d;
      left_q     <= left_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    w_q       <= w_d;
    h_q       <= h_d;
    sum_q     <= sum_d;
    div_cnt_q <= div_cnt_d;
    rem_q     <= rem_d;
    num_q     <= num_d;
    divisor_q <= divisor_d;
  end

  // The divider only runs while the texture is being worked on.
  `TMTL_ASSERT(front_div_in_calc, div_busy_q |-> (state_q == F_CALC), "divider busy outside calc")
  // A queued texture always carries a legal level count.
  `TMTL_ASSERT(front_count_legal, (state_q == F_PUSH) |-> ((job_q.count != 4'd0) && (job_q.count <= 4'(MAX_LEVELS))), "illegal level count queued")

endmodule

// ----- hdl/tmtl_back.sv -----
// Back part: walks the levels of a queued texture and emits one tile setup per
// level through an output register. Depends on tmtl_pkg.
`include "texture_mip_tile_layout_unit_macros.svh"

module tmtl_back import tmtl_pkg::*; #(
  parameter int unsigned MAX_LEVELS = MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  tmtl_job_t   pop_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  tile_index_o,
  output logic [8:0]  line_words_o,
  output logic [18:0] tmem_addr_o,
  output logic [3:0]  mask_s_o,
  output logic [3:0]  mask_t_o,
  output logic [18:0] load_last_texel_o,
  output logic [11:0] load_dxt_o,
  output logic [1:0]  load_size_code_o,
  output logic [12:0] lower_right_s_o,
  output logic [12:0] lower_right_t_o,
  output logic        last_level_o
);

  localparam int unsigned LvlW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic            busy_q, busy_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  tmtl_job_t       job_q, job_d;
  logic [10:0]     w_q, w_d, h_q, h_d;
  logic [18:0]     tmem_q, tmem_d;
  logic            out_valid_q, out_valid_d;

  logic            step;
  logic            take_job;
  logic            last_lvl;
  logic [9:0]      line;
  logic [20:0]     level_words;
  logic [10:0]     w_m1, h_m1;

  assign take_job    = pop_valid_i && !busy_q;
  assign pop_ready_o = !busy_q;
  assign step        = busy_q && (!out_valid_q || out_ready_i);
  assign last_lvl    = (lvl_q == LvlW'(job_q.count - 4'd1));
  assign line        = row_words(job_q.depth, w_q);
  assign level_words = 21'(line) * 21'(h_q);
  assign w_m1        = w_q - 11'd1;
  assign h_m1        = h_q - 11'd1;

  // Level walker: a new texture loads when idle, a level advances per step.
  always_comb begin
    busy_d      = busy_q;
    lvl_d       = lvl_q;
    job_d       = job_q;
    w_d         = w_q;
    h_d         = h_q;
    tmem_d      = tmem_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take_job) begin
      busy_d = 1'b1;
      lvl_d  = '0;
      job_d  = pop_data_i;
      w_d    = pop_data_i.w0;
      h_d    = pop_data_i.h0;
      tmem_d = '0;
    end else if (step) begin
      out_valid_d = 1'b1;
      lvl_d       = lvl_q + LvlW'(1);
      w_d         = halve(w_q);
      h_d         = halve(h_q);
      tmem_d      = tmem_q + level_words[18:0];
      if (last_lvl) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    job_q  <= job_d;
    w_q    <= w_d;
    h_q    <= h_d;
    tmem_q <= tmem_d;
  end

  // Output register, loaded on every step.
  always_ff @(posedge clk_i) begin
    if (step && !take_job) begin
      tile_index_o      <= 3'(lvl_q);
      line_words_o      <= line[8:0];
      tmem_addr_o       <= tmem_q;
      mask_s_o          <= wrap_mask(w_q);
      mask_t_o          <= wrap_mask(h_q);
      load_last_texel_o <= job_q.last;
      load_dxt_o        <= job_q.dxt;
      load_size_code_o  <= (job_q.depth == Depth32b) ? SizeCode32 : SizeCode16;
      lower_right_s_o   <= {w_m1, 2'b00} + 13'(job_q.corner);
      lower_right_t_o   <= {h_m1, 2'b00} + 13'(job_q.corner);
      last_level_o      <= last_lvl;
    end
  end

  assign out_valid_o = out_valid_q;

  // The level counter never runs past the texture's level count.
  `TMTL_ASSERT(back_lvl_in_range, busy_q |-> (4'(lvl_q) < job_q.count), "level beyond count")
  // Emitting the final level always ends the texture.
  `TMTL_ASSERT(back_last_ends_job, (step && last_lvl) |=> !busy_q, "walker busy after last level")

endmodule

// ----- sim/tb_texture_mip_tile_layout_unit.sv -----
// Self-checking testbench for texture_mip_tile_layout_unit: texture transactions in,
// one predicted tile setup per mip level compared field by field on the way out.
// Depends on tmtl_pkg and the unit's RTL only.
module tb_texture_mip_tile_layout_unit;
  import tmtl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned ItemsPerPass = 82;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StuckLimit   = 4000;
  localparam int unsigned TailCycles   = 50;

  typedef struct packed {
    logic [10:0] width;
    logic [10:0] height;
    logic [1:0]  depth;
    logic [3:0]  levels;
    logic [11:0] corner;
  } texture_t;

  typedef struct packed {
    logic [2:0]  tile_index;
    logic [8:0]  line_words;
    logic [18:0] tmem_addr;
    logic [3:0]  mask_s;
    logic [3:0]  mask_t;
    logic [18:0] load_last_texel;
    logic [11:0] load_dxt;
    logic [1:0]  load_size_code;
    logic [12:0] lower_right_s;
    logic [12:0] lower_right_t;
    logic        last_level;
  } tile_setup_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        tex_valid = 1'b0;
  logic        tex_ready;
  logic [10:0] tex_width = '0;
  logic [10:0] tex_height = '0;
  logic [1:0]  depth_code = Depth4b;
  logic [3:0]  mip_levels = '0;
  logic [11:0] corner_offset = '0;

  logic        tile_valid;
  logic        tile_ready = 1'b0;
  logic [2:0]  tile_index;
  logic [8:0]  line_words;
  logic [18:0] tmem_addr;
  logic [3:0]  mask_s;
  logic [3:0]  mask_t;
  logic [18:0] load_last_texel;
  logic [11:0] load_dxt;
  logic [1:0]  load_size_code;
  logic [12:0] lower_right_s;
  logic [12:0] lower_right_t;
  logic        last_level;

  texture_t    texture_q[$];
  tile_setup_t tile_expect_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left;
  int unsigned stuck_cycles;
  int unsigned mismatches = 0;

  texture_mip_tile_layout_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (tex_valid),
    .in_ready_o        (tex_ready),
    .tex_width_i       (tex_width),
    .tex_height_i      (tex_height),
    .depth_code_i      (depth_code),
    .mip_levels_i      (mip_levels),
    .corner_offset_i   (corner_offset),
    .out_valid_o       (tile_valid),
    .out_ready_i       (tile_ready),
    .tile_index_o      (tile_index),
    .line_words_o      (line_words),
    .tmem_addr_o       (tmem_addr),
    .mask_s_o          (mask_s),
    .mask_t_o          (mask_t),
    .load_last_texel_o (load_last_texel),
    .load_dxt_o        (load_dxt),
    .load_size_code_o  (load_size_code),
    .lower_right_s_o   (lower_right_s),
    .lower_right_t_o   (lower_right_t),
    .last_level_o      (last_level)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Row length in 64-bit words for a row of w texels at the given depth.
  function automatic int unsigned words_per_row(logic [1:0] depth, int unsigned w);
    case (depth)
      Depth4b: return (w + 15) / 16;
      Depth8b: return (w + 7) / 8;
      default: return (w + 3) / 4;
    endcase
  endfunction

  // Next mip dimension; one and zero stay where they are.
  function automatic int unsigned next_mip_dim(int unsigned v);
    return (v >= 2) ? (v >> 1) : v;
  endfunction

  // Wrap mask: exponent of the smallest power of two covering n, capped at eight.
  function automatic logic [3:0] mask_bits(int unsigned n);
    int unsigned k;
    k = 0;
    if (n >= 2) begin
      while (k < 8 && (32'd1 << k) < n) k++;
    end
    return 4'(k);
  endfunction

  // Works out every tile setup one texture transaction must produce.
  function automatic void predict_tiles(input texture_t tex);
    int unsigned n_tiles, w, h, load_words, dxt, step, grain, addr, line, lvl;
    tile_setup_t tile;
    n_tiles = (tex.levels == 0) ? 1 : tex.levels;
    if (n_tiles > MaxLevels) n_tiles = MaxLevels;

    // Load-block size over all levels that will be emitted.
    load_words = 0;
    w = tex.width;
    h = tex.height;
    for (lvl = 0; lvl < n_tiles; lvl++) begin
      load_words += words_per_row(tex.depth, w) * 4 * h;
      w = next_mip_dim(w);
      h = next_mip_dim(h);
    end

    // The dxt step exists only for a texture without mipmaps.
    dxt = 0;
    if (tex.levels == 0) begin
      case (tex.depth)
        Depth4b: grain = 16;
        Depth8b: grain = 8;
        default: grain = 4;
      endcase
      step = words_per_row(tex.depth, tex.width) * grain;
      if (step != 0) dxt = ((32'd32768 >> tex.depth) + step - 1) / step;
    end

    addr = 0;
    w = tex.width;
    h = tex.height;
    for (lvl = 0; lvl < n_tiles; lvl++) begin
      if (lvl > 0) begin
        w = next_mip_dim(w);
        h = next_mip_dim(h);
      end
      line = words_per_row(tex.depth, w);
      tile.tile_index      = 3'(lvl);
      tile.line_words      = 9'(line);
      tile.tmem_addr       = 19'(addr);
      tile.mask_s          = mask_bits(w);
      tile.mask_t          = mask_bits(h);
      tile.load_last_texel = 19'(load_words - 1);
      tile.load_dxt        = 12'(dxt);
      tile.load_size_code  = (tex.depth == Depth32b) ? SizeCode32 : SizeCode16;
      tile.lower_right_s   = 13'(((w - 1) << 2) + tex.corner);
      tile.lower_right_t   = 13'(((h - 1) << 2) + tex.corner);
      tile.last_level      = (lvl + 1 == n_tiles);
      tile_expect_q.push_back(tile);
      addr += line * h;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Dimension mix: powers of two, just past them, tiny, the whole field, typical.
  function automatic logic [10:0] random_dim();
    case ($urandom_range(9))
      0: return 11'(32'd1 << $urandom_range(10));
      1: return 11'((32'd1 << $urandom_range(9)) + 1);
      2: return 11'($urandom_range(2047));
      3: return 11'($urandom_range(3));
      default: return 11'($urandom_range(1024, 1));
    endcase
  endfunction

  function automatic texture_t random_texture();
    texture_t tex;
    tex.width  = random_dim();
    tex.height = random_dim();
    tex.depth  = 2'($urandom_range(3));
    tex.levels = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                          : 4'($urandom_range(8));
    case ($urandom_range(5))
      0: tex.corner = '0;
      1: tex.corner = '1;
      default: tex.corner = 12'($urandom_range(4095));
    endcase
    return tex;
  endfunction

  function automatic texture_t make_texture(int unsigned w, int unsigned h,
                                            logic [1:0] depth, int unsigned levels,
                                            int unsigned corner);
    texture_t tex;
    tex.width  = 11'(w);
    tex.height = 11'(h);
    tex.depth  = depth;
    tex.levels = 4'(levels);
    tex.corner = 12'(corner);
    return tex;
  endfunction

  // Driver: predicts on each accepted transaction, then offers the next texture.
  always @(posedge clk_i or negedge rst_ni) begin : texture_driver
    texture_t tex;
    if (!rst_ni) begin
      tex_valid <= 1'b0;
    end else begin
      if (tex_valid && tex_ready) begin
        predict_tiles({tex_width, tex_height, depth_code, mip_levels, corner_offset});
      end
      if (!tex_valid || tex_ready) begin
        if (texture_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          tex = texture_q.pop_front();
          tex_valid     <= 1'b1;
          tex_width     <= tex.width;
          tex_height    <= tex.height;
          depth_code    <= tex.depth;
          mip_levels    <= tex.levels;
          corner_offset <= tex.corner;
        end else begin
          tex_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_ready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req) begin
      tile_ready <= 1'b0;
      hold_left  <= HoldCycles;
    end else if (hold_left != 0) begin
      tile_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      tile_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: each accepted tile transaction is held against the oldest expectation.
  always @(posedge clk_i) begin : tile_monitor
    tile_setup_t want;
    if (rst_ni && tile_valid && tile_ready) begin
      if (tile_expect_q.size() == 0) begin
        $error("tile transaction with no texture outstanding: tile_index %0d", tile_index);
        mismatches++;
      end else begin
        want = tile_expect_q.pop_front();
        check_field("tile_index", want.tile_index, tile_index);
        check_field("line_words", want.line_words, line_words);
        check_field("tmem_addr", want.tmem_addr, tmem_addr);
        check_field("mask_s", want.mask_s, mask_s);
        check_field("mask_t", want.mask_t, mask_t);
        check_field("load_last_texel", want.load_last_texel, load_last_texel);
        check_field("load_dxt", want.load_dxt, load_dxt);
        check_field("load_size_code", want.load_size_code, load_size_code);
        check_field("lower_right_s", want.lower_right_s, lower_right_s);
        check_field("lower_right_t", want.lower_right_t, lower_right_t);
        check_field("last_level", want.last_level, last_level);
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (tex_valid && tex_ready) || (tile_valid && tile_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Blocks until every queued texture is taken and every tile setup has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (texture_q.size() != 0 || tex_valid || tile_expect_q.size() != 0);
  endtask

  // Stimulus sequence: directed corners, then random passes under different idling.
  initial begin
    int unsigned sender_pct[4];
    int unsigned receiver_pct[4];
    sender_pct   = '{0, 64, 0, 22};
    receiver_pct = '{0, 0, 64, 22};

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, every depth, single level vs. mipmapped, and the odd cases.
    texture_q.push_back(make_texture(1, 1, Depth4b, 0, 0));
    texture_q.push_back(make_texture(1024, 1024, Depth32b, 0, 4095));
    texture_q.push_back(make_texture(2047, 2047, Depth32b, 15, 4095));
    texture_q.push_back(make_texture(0, 0, Depth4b, 0, 0));
    texture_q.push_back(make_texture(0, 5, Depth8b, 3, 100));
    texture_q.push_back(make_texture(5, 0, Depth16b, 2, 7));
    texture_q.push_back(make_texture(17, 9, Depth4b, 0, 1));
    texture_q.push_back(make_texture(17, 9, Depth8b, 0, 2));
    texture_q.push_back(make_texture(17, 9, Depth16b, 0, 3));
    texture_q.push_back(make_texture(17, 9, Depth32b, 0, 4));
    texture_q.push_back(make_texture(256, 256, Depth4b, 8, 0));
    texture_q.push_back(make_texture(256, 256, Depth8b, 8, 0));
    texture_q.push_back(make_texture(256, 256, Depth16b, 8, 0));
    texture_q.push_back(make_texture(256, 256, Depth32b, 8, 0));
    texture_q.push_back(make_texture(64, 32, Depth16b, 9, 12));
    texture_q.push_back(make_texture(1024, 1024, Depth4b, 8, 0));
    texture_q.push_back(make_texture(1024, 1024, Depth32b, 8, 0));
    texture_q.push_back(make_texture(2, 3, Depth8b, 2, 0));
    texture_q.push_back(make_texture(257, 255, Depth16b, 1, 0));
    texture_q.push_back(make_texture(1024, 1, Depth8b, 8, 2048));
    texture_q.push_back(make_texture(1, 1024, Depth4b, 8, 1));
    texture_q.push_back(make_texture(2047, 1, Depth16b, 0, 4095));
    texture_q.push_back(make_texture(1, 2047, Depth8b, 0, 0));
    wait_drained();

    foreach (sender_pct[p]) begin
      send_idle_pct = sender_pct[p];
      rx_stall_pct  = receiver_pct[p];
      repeat (ItemsPerPass) texture_q.push_back(random_texture());
      // In the pass without idling, hold the receiver off so the unit backs up.
      if (p == 0) begin
        repeat (20) @(negedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
        hold_req = 1'b0;
      end
      wait_drained();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
